>>> design/arot_pkg.sv
// Shared types, constants and arithmetic helpers of the axis-angle point rotator.
`default_nettype none

package arot_pkg;

	// configuration address width and register indexes
	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_AXIS_X = 3'd0,
		REG_AXIS_Y = 3'd1,
		REG_AXIS_Z = 3'd2,
		REG_CEN_X  = 3'd3,
		REG_CEN_Y  = 3'd4,
		REG_CEN_Z  = 3'd5,
		REG_ANGLE  = 3'd6
	} reg_idx_t;

	// item kinds
	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_DIR   = 1'b1;

	// Q30 angle constants and CORDIC setup
	localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 30;

	// width of a rotated component before normalization or saturation
	localparam int RW = 40;

	// derived coefficients handed from the register block to the datapath
	typedef struct packed {
		logic [2:0][31:0] u;
		logic [2:0][31:0] cen;
		logic [33:0]      cosv;
		logic [33:0]      sinv;
	} arot_coef_t;

	// one step of the digit-by-digit square root
	typedef struct packed {
		logic [63:0] op;
		logic [63:0] res;
	} sqrt_st_t;

	function automatic sqrt_st_t sqrt_step(input sqrt_st_t a, input logic [63:0] one);
		logic [64:0] tr;
		sqrt_st_t o;
		tr = {1'b0, a.res} + {1'b0, one};
		if ({1'b0, a.op} >= tr) begin
			o.op  = a.op - tr[63:0];
			o.res = (a.res >> 1) + one;
		end else begin
			o.op  = a.op;
			o.res = a.res >> 1;
		end
		return o;
	endfunction

	// arctangent table, Q30, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:    v = 30'h3243F6A8;
			5'd1:    v = 30'h1DAC6705;
			5'd2:    v = 30'h0FADBAFC;
			5'd3:    v = 30'h07F56EA6;
			5'd4:    v = 30'h03FEAB76;
			5'd5:    v = 30'h01FFD55B;
			5'd6:    v = 30'h00FFFAAA;
			5'd7:    v = 30'h007FFF55;
			5'd8:    v = 30'h003FFFEA;
			5'd9:    v = 30'h001FFFFD;
			5'd10:   v = 30'h000FFFFF;
			5'd11:   v = 30'h0007FFFF;
			5'd12:   v = 30'h0003FFFF;
			5'd13:   v = 30'h0001FFFF;
			5'd14:   v = 30'h0000FFFF;
			5'd15:   v = 30'h00007FFF;
			5'd16:   v = 30'h00003FFF;
			5'd17:   v = 30'h00001FFF;
			5'd18:   v = 30'h00000FFF;
			5'd19:   v = 30'h000007FF;
			5'd20:   v = 30'h000003FF;
			5'd21:   v = 30'h000001FF;
			5'd22:   v = 30'h000000FF;
			5'd23:   v = 30'h0000007F;
			5'd24:   v = 30'h0000003F;
			5'd25:   v = 30'h0000001F;
			5'd26:   v = 30'h0000000F;
			5'd27:   v = 30'h00000007;
			5'd28:   v = 30'h00000003;
			5'd29:   v = 30'h00000001;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

	// magnitude product rounded half up from Q30 scale
	function automatic logic [41:0] rnd30(input logic [71:0] p);
		logic [71:0] t;
		t = p + 72'd536870912;
		return t[71:30];
	endfunction

	// apply a sign to a magnitude
	function automatic logic signed [42:0] sgnd(input logic neg, input logic [41:0] m);
		logic signed [42:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

endpackage

`default_nettype wire

>>> design/arot_if.sv
// Stream interfaces for incoming items and outgoing results.
`default_nettype none

interface arot_pt_in_if;
	logic               valid;
	logic               ready;
	logic               item_kind;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;

	modport source (output valid, item_kind, in_x, in_y, in_z, input ready);
	modport sink (input valid, item_kind, in_x, in_y, in_z, output ready);
endinterface

interface arot_pt_out_if;
	logic               valid;
	logic               ready;
	logic               kind_out;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source (output valid, kind_out, out_x, out_y, out_z, input ready);
	modport sink (input valid, kind_out, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

>>> design/arot_cfg.sv
// Register block with the setup sequencer for unit axis, cosine and sine.
`default_nettype none

module arot_cfg import arot_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output logic                    busy,
	output arot_coef_t              coef
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_SQ   = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DIV  = 5'b10000
	} seq_st_t;

	logic signed [31:0] axis_q [3];
	logic signed [31:0] cen_q [3];
	logic signed [19:0] ang_q;
	logic               wr;

	seq_st_t            state_q;
	logic [1:0]         sq_cnt_q;
	logic [63:0]        acc_q;
	sqrt_st_t           root_q;
	logic [63:0]        one_q;
	logic [61:0]        rem_q;
	logic [30:0]        quo_q;
	logic [1:0]         lane_q;
	logic [4:0]         db_q;
	logic signed [31:0] u_q [3];

	logic signed [35:0] cz_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic               cneg_q;
	logic [4:0]         cstep_q;
	logic               crun_q;

	logic [31:0]        am [3];
	logic               ash;
	logic [30:0]        msh [4];
	logic [61:0]        sqv;
	logic [63:0]        acc_nxt;
	logic [31:0]        len;
	logic [61:0]        dtry;
	logic               dge;
	logic [30:0]        quo_nxt;
	logic [31:0]        uval;
	logic [1:0]         lane_nxt;
	logic [61:0]        rem_init0;
	logic [61:0]        rem_init1;
	logic signed [35:0] z_ld;
	logic signed [35:0] z_wr;
	logic signed [35:0] z_fd;
	logic               neg_fd;
	logic signed [35:0] atan_x;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= 32'sd65536;
			cen_q[0]  <= '0;
			cen_q[1]  <= '0;
			cen_q[2]  <= '0;
			ang_q     <= '0;
		end else if (wr) begin
			case (paddr[PADDR_W-1:2])
				REG_AXIS_X: axis_q[0] <= pwdata;
				REG_AXIS_Y: axis_q[1] <= pwdata;
				REG_AXIS_Z: axis_q[2] <= pwdata;
				REG_CEN_X:  cen_q[0]  <= pwdata;
				REG_CEN_Y:  cen_q[1]  <= pwdata;
				REG_CEN_Z:  cen_q[2]  <= pwdata;
				REG_ANGLE:  ang_q     <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_AXIS_X: prdata = axis_q[0];
			REG_AXIS_Y: prdata = axis_q[1];
			REG_AXIS_Z: prdata = axis_q[2];
			REG_CEN_X:  prdata = cen_q[0];
			REG_CEN_Y:  prdata = cen_q[1];
			REG_CEN_Z:  prdata = cen_q[2];
			REG_ANGLE:  prdata = {12'd0, ang_q};
			default:    prdata = '0;
		endcase
	end

	// axis magnitudes, halved together when one of them is full scale
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			am[j] = axis_q[j][31] ? 32'(-axis_q[j]) : 32'(axis_q[j]);
		end
		ash = am[0][31] | am[1][31] | am[2][31];
		for (int j = 0; j < 3; j++) begin
			msh[j] = ash ? am[j][31:1] : am[j][30:0];
		end
		msh[3] = '0;
	end

	// sum of squares and division helpers
	always_comb begin
		sqv       = msh[sq_cnt_q] * msh[sq_cnt_q];
		acc_nxt   = acc_q + {2'd0, sqv};
		len       = root_q.res[31:0];
		dtry      = {30'd0, len} << db_q;
		dge       = rem_q >= dtry;
		quo_nxt   = quo_q;
		quo_nxt[db_q] = dge;
		if (len == '0) begin
			uval = '0;
		end else if (axis_q[lane_q][31]) begin
			uval = 32'(-$signed({1'b0, quo_nxt}));
		end else begin
			uval = {1'b0, quo_nxt};
		end
		lane_nxt  = lane_q + 2'd1;
		rem_init0 = {1'b0, msh[0], 30'd0} + {31'd0, len[31:1]};
		rem_init1 = {1'b0, msh[lane_nxt], 30'd0} + {31'd0, len[31:1]};
	end

	// setup sequencer: squares, root, then one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			sq_cnt_q <= '0;
			acc_q    <= '0;
			root_q   <= '0;
			one_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			lane_q   <= '0;
			db_q     <= '0;
			u_q[0]   <= '0;
			u_q[1]   <= '0;
			u_q[2]   <= '0;
		end else if (wr) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					acc_q    <= '0;
					sq_cnt_q <= '0;
					state_q  <= ST_SQ;
				end
				ST_SQ: begin
					acc_q    <= acc_nxt;
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == 2'd2) begin
						root_q.op  <= acc_nxt;
						root_q.res <= '0;
						one_q      <= 64'd1 << 62;
						state_q    <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (one_q == '0) begin
						lane_q  <= '0;
						db_q    <= 5'd30;
						quo_q   <= '0;
						rem_q   <= rem_init0;
						state_q <= ST_DIV;
					end else begin
						root_q <= sqrt_step(root_q, one_q);
						one_q  <= one_q >> 2;
					end
				end
				ST_DIV: begin
					if (dge) begin
						rem_q <= rem_q - dtry;
					end
					quo_q <= quo_nxt;
					if (db_q == '0) begin
						u_q[lane_q] <= uval;
						if (lane_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							lane_q <= lane_nxt;
							db_q   <= 5'd30;
							quo_q  <= '0;
							rem_q  <= rem_init1;
						end
					end else begin
						db_q <= db_q - 5'd1;
					end
				end
				ST_IDLE: ;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// angle widened to Q30, wrapped to [-pi, pi], folded to [-pi/2, pi/2]
	always_comb begin
		z_ld = $signed({{2{ang_q[19]}}, ang_q, 14'd0});
		if (z_ld > Q30_PI) begin
			z_wr = z_ld - Q30_TWO_PI;
		end else if (z_ld < -Q30_PI) begin
			z_wr = z_ld + Q30_TWO_PI;
		end else begin
			z_wr = z_ld;
		end
		if (z_wr > Q30_HALF_PI) begin
			z_fd   = z_wr - Q30_PI;
			neg_fd = 1'b1;
		end else if (z_wr < -Q30_HALF_PI) begin
			z_fd   = z_wr + Q30_PI;
			neg_fd = 1'b1;
		end else begin
			z_fd   = z_wr;
			neg_fd = 1'b0;
		end
		atan_x = $signed({6'd0, atan_q30(cstep_q)});
	end

	// CORDIC rotation, one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cz_q    <= '0;
			cx_q    <= CORDIC_GAIN;
			cy_q    <= '0;
			cneg_q  <= 1'b0;
			cstep_q <= '0;
			crun_q  <= 1'b0;
		end else if (state_q == ST_LOAD && !wr) begin
			cz_q    <= z_fd;
			cx_q    <= CORDIC_GAIN;
			cy_q    <= '0;
			cneg_q  <= neg_fd;
			cstep_q <= '0;
			crun_q  <= 1'b1;
		end else if (crun_q) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - (cy_q >>> cstep_q);
				cy_q <= cy_q + (cx_q >>> cstep_q);
				cz_q <= cz_q - atan_x;
			end else begin
				cx_q <= cx_q + (cy_q >>> cstep_q);
				cy_q <= cy_q - (cx_q >>> cstep_q);
				cz_q <= cz_q + atan_x;
			end
			cstep_q <= cstep_q + 5'd1;
			if (cstep_q == 5'(CORDIC_STEPS - 1)) begin
				crun_q <= 1'b0;
			end
		end
	end

	assign busy = state_q != ST_IDLE;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			coef.u[j]   = u_q[j];
			coef.cen[j] = cen_q[j];
		end
		coef.cosv = cneg_q ? 34'(-cx_q) : 34'(cx_q);
		coef.sinv = cneg_q ? 34'(-cy_q) : 34'(cy_q);
	end

endmodule

`default_nettype wire

>>> design/arot_rot.sv
// Seven-stage Rodrigues rotation datapath.
`default_nettype none

module arot_rot import arot_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire logic               in_kind,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire arot_coef_t         coef,
	output logic                    vld_s7,
	output logic                    kind_s7,
	output logic signed [RW-1:0]    r_s7 [3]
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic signed [32:0] p_s1 [3];
	logic [62:0]        pu_s2 [3][3];
	logic               pusg_s2 [3][3];
	logic [64:0]        pc_s2 [3];
	logic               pcsg_s2 [3];
	logic signed [35:0] dot_s3;
	logic signed [35:0] cr_s3 [3];
	logic signed [35:0] pc_s3 [3];
	logic [68:0]        kp_s4;
	logic               ksg_s4;
	logic [67:0]        crp_s4 [3];
	logic               crsg_s4 [3];
	logic signed [35:0] pc_s4 [3];
	logic signed [36:0] k_s5;
	logic signed [37:0] a_s5 [3];
	logic [67:0]        kup_s6 [3];
	logic               kusg_s6 [3];
	logic signed [37:0] a_s6 [3];

	logic signed [31:0] pin [3];
	logic signed [32:0] p_d [3];
	logic [31:0]        pm [3];
	logic [30:0]        um [3];
	logic [32:0]        cm;
	logic [32:0]        sm;
	logic signed [42:0] t [3][3];
	logic signed [42:0] pcv [3];
	logic signed [42:0] dot_d;
	logic signed [42:0] cr_d [3];
	logic [34:0]        dm;
	logic signed [35:0] omc;
	logic [33:0]        omm;
	logic [34:0]        crm [3];
	logic signed [42:0] kv;
	logic signed [42:0] crsv [3];
	logic [36:0]        km;
	logic signed [42:0] kuv [3];
	logic signed [42:0] r_d [3];

	// stage 1: offset to the center for points
	always_comb begin
		pin[0] = in_x;
		pin[1] = in_y;
		pin[2] = in_z;
		for (int i = 0; i < 3; i++) begin
			p_d[i] = $signed({pin[i][31], pin[i]}) -
				((in_kind == KIND_POINT) ? $signed({coef.cen[i][31], coef.cen[i]}) : 33'sd0);
		end
	end

	// stage 2: magnitude products with the unit axis and the cosine
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pm[i] = p_s1[i][32] ? 32'(-p_s1[i]) : p_s1[i][31:0];
			um[i] = coef.u[i][31] ? 31'(-$signed(coef.u[i])) : coef.u[i][30:0];
		end
		cm = coef.cosv[33] ? 33'(-$signed(coef.cosv)) : coef.cosv[32:0];
	end

	// stage 3: round, dot product and cross product
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				t[i][j] = sgnd(pusg_s2[i][j], rnd30({9'd0, pu_s2[i][j]}));
			end
			pcv[i] = sgnd(pcsg_s2[i], rnd30({7'd0, pc_s2[i]}));
		end
		dot_d   = t[0][0] + t[1][1] + t[2][2];
		cr_d[0] = t[1][2] - t[2][1];
		cr_d[1] = t[2][0] - t[0][2];
		cr_d[2] = t[0][1] - t[1][0];
	end

	// stage 4: dot times (1 - cos), cross times sin
	always_comb begin
		dm  = dot_s3[35] ? 35'(-dot_s3) : dot_s3[34:0];
		omc = Q30_ONE - $signed({{2{coef.cosv[33]}}, coef.cosv});
		omm = omc[35] ? 34'(-omc) : omc[33:0];
		sm  = coef.sinv[33] ? 33'(-$signed(coef.sinv)) : coef.sinv[32:0];
		for (int i = 0; i < 3; i++) begin
			crm[i] = cr_s3[i][35] ? 35'(-cr_s3[i]) : cr_s3[i][34:0];
		end
	end

	// stage 5: round, partial sums
	always_comb begin
		kv = sgnd(ksg_s4, rnd30({3'd0, kp_s4}));
		for (int i = 0; i < 3; i++) begin
			crsv[i] = sgnd(crsg_s4[i], rnd30({4'd0, crp_s4[i]}));
		end
	end

	// stage 6 and 7: k times axis, final sum and move back
	always_comb begin
		km = k_s5[36] ? 37'(-k_s5) : k_s5[36:0];
		for (int i = 0; i < 3; i++) begin
			kuv[i] = sgnd(kusg_s6[i], rnd30({4'd0, kup_s6[i]}));
			r_d[i] = 43'(a_s6[i]) + kuv[i] +
				((kind_s6 == KIND_POINT) ? 43'($signed(coef.cen[i])) : 43'sd0);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			v_s1   <= in_vld;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			vld_s7 <= v_s6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
			kind_s5 <= kind_s4;
			kind_s6 <= kind_s5;
			kind_s7 <= kind_s6;
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= p_d[i];
				for (int j = 0; j < 3; j++) begin
					pu_s2[i][j]   <= pm[i] * um[j];
					pusg_s2[i][j] <= p_s1[i][32] ^ coef.u[j][31];
				end
				pc_s2[i]   <= pm[i] * cm;
				pcsg_s2[i] <= p_s1[i][32] ^ coef.cosv[33];
				cr_s3[i]   <= cr_d[i][35:0];
				pc_s3[i]   <= pcv[i][35:0];
				crp_s4[i]  <= crm[i] * sm;
				crsg_s4[i] <= cr_s3[i][35] ^ coef.sinv[33];
				pc_s4[i]   <= pc_s3[i];
				a_s5[i]    <= 38'(pc_s4[i]) + crsv[i][37:0];
				kup_s6[i]  <= km * um[i];
				kusg_s6[i] <= k_s5[36] ^ coef.u[i][31];
				a_s6[i]    <= a_s5[i];
				r_s7[i]    <= r_d[i][RW-1:0];
			end
			dot_s3 <= dot_d[35:0];
			kp_s4  <= dm * omm;
			ksg_s4 <= dot_s3[35] ^ omc[35];
			k_s5   <= kv[36:0];
		end
	end

endmodule

`default_nettype wire

>>> design/arot_norm.sv
// Direction renormalization pipeline (root and division stages) and saturation.
`default_nettype none

module arot_norm import arot_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire logic               in_kind,
	input  wire logic signed [RW-1:0] r_in [3],
	output logic                    vld_out,
	output logic                    kind_out,
	output logic signed [31:0]      res_out [3]
);

	localparam int ROOT_ST = 32;
	localparam int QB      = 17;

	typedef struct packed {
		logic             kind;
		logic [2:0]       sg;
		logic [2:0][30:0] ms;
		logic [2:0][31:0] pres;
	} carry_t;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic             kind_s1, kind_s2, kind_s3;
	logic [RW-1:0]    rm_s1 [3];
	logic [2:0]       sg_s1, sg_s2, sg_s3;
	logic [31:0]      pres_s1 [3];
	logic [31:0]      pres_s2 [3];
	logic [31:0]      pres_s3 [3];
	logic [30:0]      ms_s2 [3];
	logic [30:0]      ms_s3 [3];
	logic [61:0]      sq_s3 [3];

	logic             rt_v_s [ROOT_ST+1];
	sqrt_st_t         rt_st_s [ROOT_ST+1];
	carry_t           rt_c_s [ROOT_ST+1];

	logic             dv_v_s [QB+1];
	logic [47:0]      dv_rem_s [QB+1][3];
	logic [QB-1:0]    dv_q_s [QB+1][3];
	logic [31:0]      dv_len_s [QB+1];
	carry_t           dv_c_s [QB+1];

	logic [RW-1:0]    rm [3];
	logic [31:0]      sat [3];
	logic [RW-1:0]    orv;
	logic [3:0]       sh;
	logic [31:0]      fin [3];

	// stage 1: magnitudes and saturated point result
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rm[i] = r_in[i][RW-1] ? RW'(-r_in[i]) : r_in[i];
			if (r_in[i] > $signed(RW'(32'sh7FFFFFFF))) begin
				sat[i] = 32'h7FFFFFFF;
			end else if (r_in[i] < -$signed(RW'(33'sh080000000))) begin
				sat[i] = 32'h80000000;
			end else begin
				sat[i] = r_in[i][31:0];
			end
		end
	end

	// stage 2: least shift that brings all magnitudes below 2^31
	always_comb begin
		orv = rm_s1[0] | rm_s1[1] | rm_s1[2];
		sh  = 4'd9;
		for (int k = 9; k >= 0; k--) begin
			if ((orv >> k) < RW'(64'h80000000)) begin
				sh = 4'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// front stages: magnitude, shift, squares, sum
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			sg_s2   <= sg_s1;
			sg_s3   <= sg_s2;
			for (int i = 0; i < 3; i++) begin
				rm_s1[i]   <= rm[i];
				sg_s1[i]   <= r_in[i][RW-1];
				pres_s1[i] <= sat[i];
				pres_s2[i] <= pres_s1[i];
				pres_s3[i] <= pres_s2[i];
				ms_s2[i]   <= 31'(rm_s1[i] >> sh);
				ms_s3[i]   <= ms_s2[i];
				sq_s3[i]   <= ms_s2[i] * ms_s2[i];
			end
			rt_st_s[0].op  <= {2'd0, sq_s3[0]} + {2'd0, sq_s3[1]} + {2'd0, sq_s3[2]};
			rt_st_s[0].res <= '0;
			rt_c_s[0].kind <= kind_s3;
			rt_c_s[0].sg   <= sg_s3;
			for (int i = 0; i < 3; i++) begin
				rt_c_s[0].ms[i]   <= ms_s3[i];
				rt_c_s[0].pres[i] <= pres_s3[i];
			end
		end
	end

	assign rt_v_s[0] = v_s4;

	// square root, one result bit per stage
	for (genvar k = 0; k < ROOT_ST; k++) begin : g_root
		localparam logic [63:0] ONE_K = 64'd1 << (62 - 2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_st_s[k+1] <= sqrt_step(rt_st_s[k], ONE_K);
				rt_c_s[k+1]  <= rt_c_s[k];
			end
		end
	end

	// division setup: (m * 2^16 + len/2) over len
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[ROOT_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[0] <= rt_st_s[ROOT_ST].res[31:0];
			dv_c_s[0]   <= rt_c_s[ROOT_ST];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= {1'b0, rt_c_s[ROOT_ST].ms[i], 16'd0} +
					{17'd0, rt_st_s[ROOT_ST].res[31:1]};
				dv_q_s[0][i]   <= '0;
			end
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	for (genvar d = 0; d < QB; d++) begin : g_div
		localparam int B = QB - 1 - d;

		logic [48:0] dtry;
		logic        dge [3];

		always_comb begin
			dtry = {17'd0, dv_len_s[d]} << B;
			for (int i = 0; i < 3; i++) begin
				dge[i] = {1'b0, dv_rem_s[d][i]} >= dtry;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[d+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[d+1] <= dv_v_s[d];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[d+1] <= dv_len_s[d];
				dv_c_s[d+1]   <= dv_c_s[d];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[d+1][i] <= dge[i] ? 48'({1'b0, dv_rem_s[d][i]} - dtry)
						: dv_rem_s[d][i];
					dv_q_s[d+1][i]    <= dv_q_s[d][i] | (QB'(dge[i]) << B);
				end
			end
		end
	end

	// result select: saturated point or signed unit direction
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_c_s[QB].kind == KIND_POINT) begin
				fin[i] = dv_c_s[QB].pres[i];
			end else if (dv_len_s[QB] == '0) begin
				fin[i] = '0;
			end else if (dv_c_s[QB].sg[i]) begin
				fin[i] = 32'(-$signed({1'b0, dv_q_s[QB][i]}));
			end else begin
				fin[i] = {15'd0, dv_q_s[QB][i]};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_out <= dv_c_s[QB].kind;
			for (int i = 0; i < 3; i++) begin
				res_out[i] <= fin[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> design/axis_angle_point_rotator.sv
// Top level of the axis-angle point rotator.
//
//   port      | dir | handshake        | payload
//   ----------+-----+------------------+------------------------------------
//   in_pt     | in  | valid / ready    | item_kind, in_x, in_y, in_z
//   out_pt    | out | valid / ready    | kind_out, out_x, out_y, out_z
//   APB       | in  | psel / penable   | paddr, pwdata, prdata (pready high)
//
// One request per cycle while out_pt is not stalled and the setup sequencer is idle;
// the path holds 7 rotation stages, 4 for magnitude, shift, squares and sum, a
// 32-stage square root, divider setup, a 17-stage divider and an output register.
// After reset and after every register write the setup sequencer runs (squares,
// serial root, one quotient bit per cycle for the axis, CORDIC alongside);
// in_pt.ready stays low until it is done.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module axis_angle_point_rotator import arot_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	arot_pt_in_if.sink              in_pt,
	arot_pt_out_if.source           out_pt
);

	arot_coef_t         coef;
	logic               busy;
	logic               en;
	logic               acc;
	logic               rot_vld;
	logic               rot_kind;
	logic signed [RW-1:0] rot_r [3];
	logic               nrm_vld;
	logic               nrm_kind;
	logic signed [31:0] nrm_res [3];

	// pipeline advances whenever the output slot is free
	assign en           = !nrm_vld || out_pt.ready;
	assign in_pt.ready  = en && !busy;
	assign acc          = in_pt.valid && in_pt.ready;

	arot_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.busy    (busy),
		.coef    (coef)
	);

	arot_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (acc),
		.in_kind (in_pt.item_kind),
		.in_x    (in_pt.in_x),
		.in_y    (in_pt.in_y),
		.in_z    (in_pt.in_z),
		.coef    (coef),
		.vld_s7  (rot_vld),
		.kind_s7 (rot_kind),
		.r_s7    (rot_r)
	);

	arot_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (rot_vld),
		.in_kind  (rot_kind),
		.r_in     (rot_r),
		.vld_out  (nrm_vld),
		.kind_out (nrm_kind),
		.res_out  (nrm_res)
	);

	assign out_pt.valid    = nrm_vld;
	assign out_pt.kind_out = nrm_kind;
	assign out_pt.out_x    = nrm_res[0];
	assign out_pt.out_y    = nrm_res[1];
	assign out_pt.out_z    = nrm_res[2];

endmodule

`default_nettype wire
